>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("assertion failed");

`endif

>>> hw/rtl/gwwb_pkg.sv
// Shared constants, state type and command/status structs for the white balance block
package gwwb_pkg;

    localparam int PIX_W  = 8;
    localparam int FRAC_W = 16;
    localparam int GAIN_W = PIX_W + FRAC_W;
    localparam int SUM_W  = 28;
    localparam int TOT_W  = SUM_W + 2;
    localparam int DVD_W  = TOT_W + FRAC_W;
    localparam int CNT_W  = $clog2(DVD_W);
    localparam int PROD_W = PIX_W + GAIN_W;
    localparam int NCH    = 3;
    localparam int CH_W   = 2;

    localparam logic [CH_W-1:0] CH_B    = CH_W'(0);
    localparam logic [CH_W-1:0] CH_G    = CH_W'(1);
    localparam logic [CH_W-1:0] CH_R    = CH_W'(2);
    localparam logic [CH_W-1:0] CH_LAST = CH_R;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_INIT,
        ST_STEP,
        ST_STORE
    } t_state;

    typedef struct packed {
        logic            acc;
        logic            mul;
        logic            tot;
        logic            init;
        logic            step;
        logic            store;
        logic            clear;
        logic [CH_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_stat;

endpackage

>>> hw/rtl/gwwb_ctrl.sv
// Controller state machine: request intake and gain division sequencing
module gwwb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_func,
    input  logic             i_last_pixel,
    input  gwwb_pkg::t_stat  i_stat,
    output gwwb_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    import gwwb_pkg::*;

    t_state          r_state;
    t_state          n_state;
    logic [CH_W-1:0] r_ch;
    logic [CH_W-1:0] n_ch;
    logic            take;

    assign take = i_start && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= CH_B;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        case (r_state)
            ST_IDLE: begin
                n_ch = CH_B;
                if (take && !i_func && i_last_pixel) begin
                    n_state = ST_TOTAL;
                end
            end
            ST_TOTAL: begin
                n_state = ST_INIT;
            end
            ST_INIT: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (i_stat.div_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                if (r_ch == CH_LAST) begin
                    n_state = ST_IDLE;
                    n_ch    = CH_B;
                end else begin
                    n_state = ST_INIT;
                    n_ch    = r_ch + CH_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_ch    = CH_B;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.ch    = r_ch;
        o_busy      = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy    = 1'b0;
                o_cmd.acc = take && !i_func;
                o_cmd.mul = take && i_func;
            end
            ST_TOTAL: begin
                o_cmd.tot = 1'b1;
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                o_cmd.clear = (r_ch == CH_LAST);
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

>>> hw/rtl/gwwb_dp.sv
// Datapath: channel sums, shared restoring divider, gains and correction multipliers
module gwwb_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gwwb_pkg::t_cmd              i_cmd,
    input  logic [gwwb_pkg::PIX_W-1:0]  i_pix_b,
    input  logic [gwwb_pkg::PIX_W-1:0]  i_pix_g,
    input  logic [gwwb_pkg::PIX_W-1:0]  i_pix_r,
    input  logic                        i_last_pixel,
    output gwwb_pkg::t_stat             o_stat,
    output logic [gwwb_pkg::PIX_W-1:0]  o_out_b,
    output logic [gwwb_pkg::PIX_W-1:0]  o_out_g,
    output logic [gwwb_pkg::PIX_W-1:0]  o_out_r,
    output logic                        o_out_last,
    output logic                        o_strobe
);
    import gwwb_pkg::*;

    logic [PIX_W-1:0]  pix [NCH];
    logic [SUM_W-1:0]  r_sum [NCH];
    logic [SUM_W:0]    sum_add [NCH];
    logic [GAIN_W-1:0] r_gain [NCH];
    logic [TOT_W-1:0]  r_tot;
    logic [TOT_W-1:0]  r_dvs;
    logic [DVD_W-1:0]  r_dvd;
    logic [TOT_W-1:0]  r_rem;
    logic [GAIN_W-1:0] r_quo;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  sel_sum;
    logic [TOT_W:0]    rem_sh;
    logic [TOT_W:0]    rem_sub;
    logic              ge;
    logic [PROD_W-1:0] r_prod [NCH];
    logic              r_mval;
    logic              r_mlast;
    logic [PIX_W-1:0]  r_out [NCH];
    logic              r_strobe;
    logic              r_olast;

    assign pix[0] = i_pix_b;
    assign pix[1] = i_pix_g;
    assign pix[2] = i_pix_r;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            sum_add[c] = {1'b0, r_sum[c]} + (SUM_W+1)'(pix[c]);
        end
    end

    always_comb begin
        case (i_cmd.ch)
            CH_B:    sel_sum = r_sum[0];
            CH_G:    sel_sum = r_sum[1];
            CH_R:    sel_sum = r_sum[2];
            default: sel_sum = '0;
        endcase
    end

    assign rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign ge      = (rem_sh >= {1'b0, r_dvs});

    assign o_stat.div_last = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                r_sum[c]  <= '0;
                r_gain[c] <= '0;
            end
        end else begin
            for (int c = 0; c < NCH; c++) begin
                if (i_cmd.clear) begin
                    r_sum[c] <= '0;
                end else if (i_cmd.acc) begin
                    r_sum[c] <= sum_add[c][SUM_W] ? '1 : sum_add[c][SUM_W-1:0];
                end
            end
            if (i_cmd.store) begin
                case (i_cmd.ch)
                    CH_B:    r_gain[0] <= (r_dvs == '0) ? '0 : (r_ovf ? '1 : r_quo);
                    CH_G:    r_gain[1] <= (r_dvs == '0) ? '0 : (r_ovf ? '1 : r_quo);
                    CH_R:    r_gain[2] <= (r_dvs == '0) ? '0 : (r_ovf ? '1 : r_quo);
                    default: r_gain[0] <= r_gain[0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tot) begin
            r_tot <= TOT_W'(r_sum[0]) + TOT_W'(r_sum[1]) + TOT_W'(r_sum[2]);
        end
        if (i_cmd.init) begin
            r_dvs <= {1'b0, sel_sum, 1'b0} + TOT_W'(sel_sum);
            r_dvd <= {r_tot, {FRAC_W{1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.step) begin
            r_rem <= ge ? rem_sub[TOT_W-1:0] : rem_sh[TOT_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[GAIN_W-2:0], ge};
            r_ovf <= r_ovf | r_quo[GAIN_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.init) begin
            r_cnt <= CNT_W'(DVD_W - 1);
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mval   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_mval   <= i_cmd.mul;
            r_strobe <= r_mval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            for (int c = 0; c < NCH; c++) begin
                r_prod[c] <= PROD_W'(pix[c]) * PROD_W'(r_gain[c]);
            end
            r_mlast <= i_last_pixel;
        end
        if (r_mval) begin
            for (int c = 0; c < NCH; c++) begin
                r_out[c] <= (r_prod[c][PROD_W-1:FRAC_W+PIX_W] != '0) ? '1
                          : r_prod[c][FRAC_W+PIX_W-1:FRAC_W];
            end
            r_olast <= r_mlast;
        end
    end

    assign o_out_b    = r_out[0];
    assign o_out_g    = r_out[1];
    assign o_out_r    = r_out[2];
    assign o_out_last = r_olast;
    assign o_strobe   = r_strobe;

endmodule

>>> hw/rtl/gray_world_white_balance.sv
// Top level of the gray-world white balance block
//
//  port group          direction  marker          accepted when
//  request  (i_func..) in         start / busy    start high and busy low at the edge
//  result   (o_out_..) out        o_strobe        o_strobe high at the edge
//
// A statistics pixel yields no result.
// Correction pixels may follow every cycle if not busy; results pass r_prod, then r_out.
// The last statistics pixel holds busy while the shared divider handles each channel,
// retiring one quotient bit per cycle.
// Reset is synchronous, active low; it clears sums and gains to zero.
// The receiver cannot stall; each result stands for exactly one cycle.
module gray_world_white_balance (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [gwwb_pkg::PIX_W-1:0]  i_pix_b,
    input  logic [gwwb_pkg::PIX_W-1:0]  i_pix_g,
    input  logic [gwwb_pkg::PIX_W-1:0]  i_pix_r,
    input  logic                        i_last_pixel,
    output logic [gwwb_pkg::PIX_W-1:0]  o_out_b,
    output logic [gwwb_pkg::PIX_W-1:0]  o_out_g,
    output logic [gwwb_pkg::PIX_W-1:0]  o_out_r,
    output logic                        o_out_last,
    output logic                        o_strobe
);
    import gwwb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    gwwb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_func       (i_func),
        .i_last_pixel (i_last_pixel),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_busy       (busy)
    );

    gwwb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_pix_b      (i_pix_b),
        .i_pix_g      (i_pix_g),
        .i_pix_r      (i_pix_r),
        .i_last_pixel (i_last_pixel),
        .o_stat       (stat),
        .o_out_b      (o_out_b),
        .o_out_g      (o_out_g),
        .o_out_r      (o_out_r),
        .o_out_last   (o_out_last),
        .o_strobe     (o_strobe)
    );

endmodule

>>> hw/rtl/gwwb_chk.sv
// Port-level checker for the white balance block and its bind
`include "assert_macros.svh"

module gwwb_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_func,
    input logic i_last_pixel,
    input logic o_strobe
);

    `ASSERT_NEXT(a_last_stat_busy, i_clk, i_rst_n, start && !busy && !i_func && i_last_pixel, busy)
    `ASSERT_NEXT(a_corr_result, i_clk, i_rst_n, start && !busy && i_func, ##1 o_strobe)
    `ASSERT_IMPLY(a_result_source, i_clk, i_rst_n, o_strobe, $past(start && !busy && i_func, 2))
    `ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !busy && !(start && !i_func && i_last_pixel), !busy)

endmodule

bind gray_world_white_balance gwwb_chk u_chk (.*);

>>> bench/gray_world_white_balance_tb.sv
// Self-checking testbench for the gray-world white balance block: statistics and correction passes
`timescale 1ns / 100ps

module gray_world_white_balance_tb;
    import gwwb_pkg::*;

    localparam logic FUNC_STATS   = 1'b0;
    localparam logic FUNC_CORRECT = 1'b1;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   SHOWN_MAX    = 10;
    localparam int   CALM_ITEMS   = 330;
    localparam int   TOTAL_ITEMS  = 400;

    typedef struct packed {
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;
        logic             last;
    } t_pix_result;

    class gwwb_scoreboard;
        logic [SUM_W-1:0]  sum_b, sum_g, sum_r;
        logic [GAIN_W-1:0] gain_b, gain_g, gain_r;
        t_pix_result       balanced_q[$];
        int                errors;

        function new();
            sum_b  = '0;
            sum_g  = '0;
            sum_r  = '0;
            gain_b = '0;
            gain_g = '0;
            gain_r = '0;
            errors = 0;
        endfunction

        function logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] sum, logic [PIX_W-1:0] p);
            logic [SUM_W:0] s;
            s = {1'b0, sum} + (SUM_W+1)'(p);
            return s[SUM_W] ? '1 : s[SUM_W-1:0];
        endfunction

        function logic [GAIN_W-1:0] channel_gain(logic [63:0] total, logic [SUM_W-1:0] sum_c);
            logic [63:0] q;
            if (sum_c == '0)
                return '0;
            q = (total << FRAC_W) / (64'd3 * 64'(sum_c));
            return (q[63:GAIN_W] != '0) ? '1 : q[GAIN_W-1:0];
        endfunction

        function logic [PIX_W-1:0] apply_gain(logic [PIX_W-1:0] p, logic [GAIN_W-1:0] gain);
            logic [63:0] v;
            v = (64'(p) * 64'(gain)) >> FRAC_W;
            return (v[63:PIX_W] != '0) ? '1 : v[PIX_W-1:0];
        endfunction

        function void note_request(logic func, logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                                   logic [PIX_W-1:0] r, logic last);
            logic [63:0] total;
            t_pix_result res;
            if (func == FUNC_STATS) begin
                sum_b = add_sat(sum_b, b);
                sum_g = add_sat(sum_g, g);
                sum_r = add_sat(sum_r, r);
                if (last) begin
                    total  = 64'(sum_b) + 64'(sum_g) + 64'(sum_r);
                    gain_b = channel_gain(total, sum_b);
                    gain_g = channel_gain(total, sum_g);
                    gain_r = channel_gain(total, sum_r);
                    sum_b  = '0;
                    sum_g  = '0;
                    sum_r  = '0;
                end
            end else begin
                res.b    = apply_gain(b, gain_b);
                res.g    = apply_gain(g, gain_g);
                res.r    = apply_gain(r, gain_r);
                res.last = last;
                balanced_q.push_back(res);
            end
        endfunction

        function void report(string what, t_pix_result want, t_pix_result got);
            errors++;
            if (errors <= SHOWN_MAX)
                $display("%s: expected b=%0d g=%0d r=%0d last=%0b, got b=%0d g=%0d r=%0d last=%0b",
                         what, want.b, want.g, want.r, want.last,
                         got.b, got.g, got.r, got.last);
        endfunction

        function void check_result(t_pix_result got);
            t_pix_result want;
            if (balanced_q.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = balanced_q.pop_front();
            if (got.b !== want.b || got.g !== want.g || got.r !== want.r
                || got.last !== want.last)
                report("result mismatch", want, got);
        endfunction

        function int pending();
            return balanced_q.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_func;
    logic [PIX_W-1:0] i_pix_b;
    logic [PIX_W-1:0] i_pix_g;
    logic [PIX_W-1:0] i_pix_r;
    logic             i_last_pixel;
    logic [PIX_W-1:0] o_out_b;
    logic [PIX_W-1:0] o_out_g;
    logic [PIX_W-1:0] o_out_r;
    logic             o_out_last;
    logic             o_strobe;

    gwwb_scoreboard sb;
    int             items_sent;
    int             cycle_count;

    gray_world_white_balance dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_pix_b      (i_pix_b),
        .i_pix_g      (i_pix_g),
        .i_pix_r      (i_pix_r),
        .i_last_pixel (i_last_pixel),
        .o_out_b      (o_out_b),
        .o_out_g      (o_out_g),
        .o_out_r      (o_out_r),
        .o_out_last   (o_out_last),
        .o_strobe     (o_strobe)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_request(i_func, i_pix_b, i_pix_g, i_pix_r, i_last_pixel);
            if (o_strobe)
                sb.check_result('{o_out_b, o_out_g, o_out_r, o_out_last});
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("gray_world_white_balance test failed");
        $finish;
    end

    task automatic send_pixel(input logic func, input logic [PIX_W-1:0] b,
                              input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] r,
                              input logic last);
        start        <= 1'b1;
        i_func       <= func;
        i_pix_b      <= b;
        i_pix_g      <= g;
        i_pix_r      <= r;
        i_last_pixel <= last;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic pause(input int n);
        start        <= 1'b0;
        i_func       <= 1'($urandom);
        i_pix_b      <= PIX_W'($urandom);
        i_pix_g      <= PIX_W'($urandom);
        i_pix_r      <= PIX_W'($urandom);
        i_last_pixel <= 1'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_pause(input bit idle_on);
        if (idle_on && $urandom_range(0, 3) == 0)
            pause($urandom_range(1, 15));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_cap();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return PIX_W'($urandom_range(1, 4));
            3, 4:    return PIX_W'($urandom_range(1, 255));
            default: return '1;
        endcase
    endfunction

    // present one frame as a statistics pass, then a correction pass of zero or more pixels
    task automatic run_frame(input bit idle_on);
        logic [PIX_W-1:0] fb[$], fg[$], fr[$];
        logic [PIX_W-1:0] cap_b, cap_g, cap_r;
        int               n_stats, n_corr, k;
        bit               broken, noisy;
        cap_b   = pick_cap();
        cap_g   = pick_cap();
        cap_r   = pick_cap();
        n_stats = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        n_corr  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
        broken  = ($urandom_range(0, 9) == 0);
        noisy   = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < n_stats; i++) begin
            fb.push_back(PIX_W'($urandom_range(0, cap_b)));
            fg.push_back(PIX_W'($urandom_range(0, cap_g)));
            fr.push_back(PIX_W'($urandom_range(0, cap_r)));
            send_pixel(FUNC_STATS, fb[i], fg[i], fr[i], !broken && i == n_stats - 1);
            maybe_pause(idle_on);
        end
        for (int j = 0; j < n_corr; j++) begin
            k = j % n_stats;
            if (noisy)
                send_pixel(FUNC_CORRECT, PIX_W'($urandom), PIX_W'($urandom),
                           PIX_W'($urandom), 1'($urandom));
            else
                send_pixel(FUNC_CORRECT, fb[k], fg[k], fr[k], j == n_corr - 1);
            maybe_pause(idle_on);
        end
    endtask

    initial begin
        sb           = new();
        items_sent   = 0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_func       <= FUNC_STATS;
        i_pix_b      <= '0;
        i_pix_g      <= '0;
        i_pix_r      <= '0;
        i_last_pixel <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // correct before any statistics: gains are zero
        send_pixel(FUNC_CORRECT, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(FUNC_CORRECT, 8'd0, 8'd0, 8'd0, 1'b1);
        // blue sum zero, red gain saturates
        send_pixel(FUNC_STATS, 8'd0, 8'd255, 8'd1, 1'b0);
        send_pixel(FUNC_STATS, 8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(FUNC_STATS, 8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(FUNC_STATS, 8'd0, 8'd255, 8'd0, 1'b1);
        send_pixel(FUNC_CORRECT, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(FUNC_CORRECT, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(FUNC_CORRECT, 8'd1, 8'd128, 8'd1, 1'b0);
        send_pixel(FUNC_CORRECT, 8'd200, 8'd7, 8'd255, 1'b1);
        // balanced frame: unity gains
        send_pixel(FUNC_STATS, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(FUNC_STATS, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(FUNC_CORRECT, 8'd255, 8'd0, 8'd170, 1'b0);
        send_pixel(FUNC_CORRECT, 8'd85, 8'd170, 8'd255, 1'b1);
        // one-pixel frame
        send_pixel(FUNC_STATS, 8'd1, 8'd2, 8'd3, 1'b1);
        send_pixel(FUNC_CORRECT, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(FUNC_CORRECT, 8'd3, 8'd2, 8'd1, 1'b1);
        // all-black frame: every gain zero
        send_pixel(FUNC_STATS, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(FUNC_CORRECT, 8'd255, 8'd128, 8'd127, 1'b1);
        // back-to-back statistics passes, the first one replaced
        send_pixel(FUNC_STATS, 8'd128, 8'd64, 8'd32, 1'b1);
        send_pixel(FUNC_STATS, 8'd10, 8'd200, 8'd90, 1'b1);
        send_pixel(FUNC_CORRECT, 8'd10, 8'd200, 8'd90, 1'b1);
        drain();

        while (items_sent < CALM_ITEMS) begin
            run_frame($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                drain();
            else if ($urandom_range(0, 1) == 0)
                pause($urandom_range(1, 15));
        end
        while (items_sent < TOTAL_ITEMS)
            run_frame(1'b0);

        drain();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("gray_world_white_balance test passed");
        else
            $display("gray_world_white_balance test failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/gwwb_pkg.sv
hw/rtl/gwwb_ctrl.sv
hw/rtl/gwwb_dp.sv
hw/rtl/gray_world_white_balance.sv
hw/rtl/gwwb_chk.sv
bench/gray_world_white_balance_tb.sv
